FILE: hdl/wslt_pkg.sv
// wslt_pkg: shared types, widths and constants for the wrapped slew-limited tracker
// no dependencies; compiled first
`timescale 1ns / 1ps

package wslt_pkg;

   localparam int POS_BITS    = 15;
   localparam int SIZE_BITS   = 10;
   localparam int WORLD_BITS  = 14;
   localparam int OUT_BITS    = 16;
   localparam int TARGET_BITS = 17;

   localparam int COORD_BITS_DEFAULT = 16;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = WORLD_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WORLD_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WORLD_HEIGHT = 1'b1;

   localparam logic [WORLD_BITS-1:0] WORLD_WIDTH_RESET  = 14'd8192;
   localparam logic [WORLD_BITS-1:0] WORLD_HEIGHT_RESET = 14'd2048;

   localparam int SNAP_DIST   = 640;
   localparam int STEP_SIZE   = 16;
   localparam int VIEW_HALF_W = 64;
   localparam int VIEW_HALF_H = 48;

   typedef struct packed {
      logic                        object_present;
      logic                        has_motion_goal;
      logic                        asleep;
      logic signed [POS_BITS-1:0]  goal_x;
      logic signed [POS_BITS-1:0]  goal_y;
      logic signed [POS_BITS-1:0]  source_x;
      logic signed [POS_BITS-1:0]  source_y;
      logic [SIZE_BITS-1:0]        object_width;
      logic [SIZE_BITS-1:0]        object_height;
   } item_type;

   typedef struct packed {
      logic signed [TARGET_BITS-1:0] x;
      logic signed [TARGET_BITS-1:0] y;
   } point_type;

endpackage

FILE: hdl/wslt_req_if.sv
// wslt_req_if: input channel carrying one tick's view of the tracked object
// depends on wslt_pkg
`timescale 1ns / 1ps

interface wslt_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 object_present;
   logic                                 has_motion_goal;
   logic                                 asleep;
   logic signed [wslt_pkg::POS_BITS-1:0] goal_x;
   logic signed [wslt_pkg::POS_BITS-1:0] goal_y;
   logic signed [wslt_pkg::POS_BITS-1:0] source_x;
   logic signed [wslt_pkg::POS_BITS-1:0] source_y;
   logic [wslt_pkg::SIZE_BITS-1:0]       object_width;
   logic [wslt_pkg::SIZE_BITS-1:0]       object_height;

   modport source (
      output valid, object_present, has_motion_goal, asleep,
      output goal_x, goal_y, source_x, source_y, object_width, object_height,
      input  ready
   );

   modport sink (
      input  valid, object_present, has_motion_goal, asleep,
      input  goal_x, goal_y, source_x, source_y, object_width, object_height,
      output ready
   );
endinterface

FILE: hdl/wslt_rsp_if.sv
// wslt_rsp_if: result channel carrying the tracked centre and its viewport
// depends on wslt_pkg
`timescale 1ns / 1ps

interface wslt_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [wslt_pkg::OUT_BITS-1:0] centre_x;
   logic signed [wslt_pkg::OUT_BITS-1:0] centre_y;
   logic signed [wslt_pkg::OUT_BITS-1:0] view_left;
   logic signed [wslt_pkg::OUT_BITS-1:0] view_top;
   logic signed [wslt_pkg::OUT_BITS-1:0] view_right;
   logic signed [wslt_pkg::OUT_BITS-1:0] view_bottom;

   modport source (
      output valid, centre_x, centre_y, view_left, view_top, view_right, view_bottom,
      input  ready
   );

   modport sink (
      input  valid, centre_x, centre_y, view_left, view_top, view_right, view_bottom,
      output ready
   );
endinterface

FILE: hdl/wslt_target.sv
// wslt_target: picks the target point, motion goal or wrapped object centre
// depends on wslt_pkg
`timescale 1ns / 1ps

module wslt_target (
   input  wslt_pkg::item_type                    item,
   input  logic [wslt_pkg::WORLD_BITS-1:0]       world_width,
   input  logic [wslt_pkg::WORLD_BITS-1:0]       world_height,
   output wslt_pkg::point_type                   target
);
   import wslt_pkg::*;

   logic signed [TARGET_BITS-1:0] ww_ext;
   logic signed [TARGET_BITS-1:0] wh_ext;
   logic signed [TARGET_BITS-1:0] gx_ext;
   logic signed [TARGET_BITS-1:0] gy_ext;
   logic signed [TARGET_BITS-1:0] centre_x_raw;
   logic signed [TARGET_BITS-1:0] centre_x_wrap;
   logic signed [TARGET_BITS-1:0] centre_y;
   logic                          goal_ok;

   assign ww_ext = TARGET_BITS'(world_width);
   assign wh_ext = TARGET_BITS'(world_height);
   assign gx_ext = TARGET_BITS'(item.goal_x);
   assign gy_ext = TARGET_BITS'(item.goal_y);

   assign centre_x_raw = TARGET_BITS'(item.source_x)
                       + TARGET_BITS'(item.object_width[SIZE_BITS-1:1]);
   assign centre_y     = TARGET_BITS'(item.source_y)
                       + TARGET_BITS'(item.object_height[SIZE_BITS-1:1]);

   // single wrap into the cyclic world
   always_comb begin
      if (centre_x_raw >= ww_ext) begin
         centre_x_wrap = centre_x_raw - ww_ext;
      end else if (centre_x_raw < 0) begin
         centre_x_wrap = centre_x_raw + ww_ext;
      end else begin
         centre_x_wrap = centre_x_raw;
      end
   end

   assign goal_ok = item.has_motion_goal && !item.asleep && !(gy_ext > wh_ext);

   always_comb begin
      if (goal_ok) begin
         target.x = gx_ext;
         target.y = gy_ext;
      end else begin
         target.x = centre_x_wrap;
         target.y = centre_y;
      end
   end

endmodule

FILE: hdl/wslt_step.sv
// wslt_step: folds the x distance and moves the stored centre toward the target
// depends on wslt_pkg
`timescale 1ns / 1ps

module wslt_step #(
   parameter int COORD_BITS = wslt_pkg::COORD_BITS_DEFAULT
) (
   input  wslt_pkg::point_type              target,
   input  logic [wslt_pkg::WORLD_BITS-1:0]  world_width,
   input  logic signed [COORD_BITS-1:0]     tracked_x,
   input  logic signed [COORD_BITS-1:0]     tracked_y,
   input  logic                             tracked_valid,
   output logic signed [COORD_BITS-1:0]     next_x,
   output logic signed [COORD_BITS-1:0]     next_y
);
   import wslt_pkg::*;

   localparam int CALC_BITS =
      ((COORD_BITS > TARGET_BITS) ? COORD_BITS : TARGET_BITS) + 3;

   localparam logic signed [CALC_BITS-1:0] SNAP_POS = CALC_BITS'(SNAP_DIST);
   localparam logic signed [CALC_BITS-1:0] SNAP_NEG = -CALC_BITS'(SNAP_DIST);
   localparam logic signed [CALC_BITS-1:0] STEP     = CALC_BITS'(STEP_SIZE);

   logic signed [CALC_BITS-1:0] tx;
   logic signed [CALC_BITS-1:0] ty;
   logic signed [CALC_BITS-1:0] cx;
   logic signed [CALC_BITS-1:0] cy;
   logic signed [CALC_BITS-1:0] ww;
   logic signed [CALC_BITS-1:0] half;
   logic signed [CALC_BITS-1:0] dist_raw;
   logic signed [CALC_BITS-1:0] dist_fold;
   logic signed [CALC_BITS-1:0] cx_dec;
   logic signed [CALC_BITS-1:0] cx_inc;
   logic signed [CALC_BITS-1:0] cy_dec;
   logic signed [CALC_BITS-1:0] cy_inc;
   logic signed [CALC_BITS-1:0] nx;
   logic signed [CALC_BITS-1:0] ny;
   logic                        snap;

   assign tx   = CALC_BITS'(target.x);
   assign ty   = CALC_BITS'(target.y);
   assign cx   = CALC_BITS'(tracked_x);
   assign cy   = CALC_BITS'(tracked_y);
   assign ww   = CALC_BITS'(world_width);
   assign half = CALC_BITS'(world_width[WORLD_BITS-1:1]);

   assign dist_raw = tx - cx;

   // fold once across the world seam
   always_comb begin
      if (dist_raw < -half) begin
         dist_fold = dist_raw + ww;
      end else if (dist_raw > half) begin
         dist_fold = dist_raw - ww;
      end else begin
         dist_fold = dist_raw;
      end
   end

   assign snap = !tracked_valid || (dist_fold > SNAP_POS) || (dist_fold < SNAP_NEG);

   assign cx_dec = cx - STEP;
   assign cx_inc = cx + STEP;
   assign cy_dec = cy - STEP;
   assign cy_inc = cy + STEP;

   always_comb begin
      if (snap) begin
         nx = tx;
      end else if (dist_fold < 0) begin
         nx = (cx_dec < tx) ? tx : cx_dec;
      end else if (dist_fold > 0) begin
         nx = (cx_inc > tx) ? tx : cx_inc;
      end else begin
         nx = cx;
      end
   end

   always_comb begin
      if (snap) begin
         ny = ty;
      end else if (cy < ty) begin
         ny = (cy_inc > ty) ? ty : cy_inc;
      end else if (cy > ty) begin
         ny = (cy_dec < ty) ? ty : cy_dec;
      end else begin
         ny = cy;
      end
   end

   assign next_x = nx[COORD_BITS-1:0];
   assign next_y = ny[COORD_BITS-1:0];

endmodule

FILE: hdl/wrapped_slew_limited_tracker_unit.sv
// wrapped_slew_limited_tracker_unit: top level, registers, handshake and csr port
// depends on wslt_pkg, wslt_req_if, wslt_rsp_if, wslt_target, wslt_step
`timescale 1ns / 1ps
//
// usage
//   req_chan (valid/ready) carries one tick's view of the tracked object. a
//   transaction with object_present low is consumed and gives no result and
//   no state change. each present transaction gives one rsp_chan transaction
//   with the new tracked centre and its 128 by 96 viewport.
//   csr_write_enable/csr_index/csr_write_data write world_width (index 0) and
//   world_height (index 1); write only while the block is idle.
// timing
//   a transaction is captured in an input register; target select, distance
//   fold and step run combinationally from there into the tracked-centre and
//   result registers. one transaction per cycle is sustained while rsp ready
//   is high, as each transaction reads the tracked centre that the one
//   before it has just written.
// reset and stalls
//   reset clears both valid flags and the tracked centre and loads the default
//   world size. when rsp ready is low the result holds in its register, one
//   more transaction waits in the input register, and req ready then drops.
//
module wrapped_slew_limited_tracker_unit #(
   parameter int COORD_BITS = wslt_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   wslt_req_if.sink                              req_chan,
   wslt_rsp_if.source                            rsp_chan,
   input  logic                                  csr_write_enable,
   input  logic [wslt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [wslt_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   import wslt_pkg::*;

   logic [WORLD_BITS-1:0] world_width_ff;
   logic [WORLD_BITS-1:0] world_height_ff;

   logic     s1_valid_ff;
   item_type s1_item_ff;
   logic     s1_advance;
   logic     req_take;
   logic     rsp_free;

   logic signed [COORD_BITS-1:0] tracked_x_ff;
   logic signed [COORD_BITS-1:0] tracked_y_ff;
   logic                         tracked_valid_ff;
   logic signed [COORD_BITS-1:0] tracked_x_in;
   logic signed [COORD_BITS-1:0] tracked_y_in;

   point_type target;

   logic signed [OUT_BITS-1:0] centre_x_in;
   logic signed [OUT_BITS-1:0] centre_y_in;

   logic                       rsp_valid_ff;
   logic signed [OUT_BITS-1:0] centre_x_ff;
   logic signed [OUT_BITS-1:0] centre_y_ff;
   logic signed [OUT_BITS-1:0] view_left_ff;
   logic signed [OUT_BITS-1:0] view_top_ff;
   logic signed [OUT_BITS-1:0] view_right_ff;
   logic signed [OUT_BITS-1:0] view_bottom_ff;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         world_width_ff  <= WORLD_WIDTH_RESET;
         world_height_ff <= WORLD_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WORLD_WIDTH: begin
               world_width_ff <= csr_write_data;
            end
            CSR_WORLD_HEIGHT: begin
               world_height_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   // handshake
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_advance     = s1_valid_ff && (!s1_item_ff.object_present || rsp_free);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.object_present  <= req_chan.object_present;
         s1_item_ff.has_motion_goal <= req_chan.has_motion_goal;
         s1_item_ff.asleep          <= req_chan.asleep;
         s1_item_ff.goal_x          <= req_chan.goal_x;
         s1_item_ff.goal_y          <= req_chan.goal_y;
         s1_item_ff.source_x        <= req_chan.source_x;
         s1_item_ff.source_y        <= req_chan.source_y;
         s1_item_ff.object_width    <= req_chan.object_width;
         s1_item_ff.object_height   <= req_chan.object_height;
      end
   end

   wslt_target u_target (
      .item         (s1_item_ff),
      .world_width  (world_width_ff),
      .world_height (world_height_ff),
      .target       (target)
   );

   wslt_step #(
      .COORD_BITS (COORD_BITS)
   ) u_step (
      .target        (target),
      .world_width   (world_width_ff),
      .tracked_x     (tracked_x_ff),
      .tracked_y     (tracked_y_ff),
      .tracked_valid (tracked_valid_ff),
      .next_x        (tracked_x_in),
      .next_y        (tracked_y_in)
   );

   // tracked centre
   always_ff @(posedge clock) begin
      if (reset) begin
         tracked_x_ff     <= '0;
         tracked_y_ff     <= '0;
         tracked_valid_ff <= 1'b0;
      end else if (s1_advance && s1_item_ff.object_present) begin
         tracked_x_ff     <= tracked_x_in;
         tracked_y_ff     <= tracked_y_in;
         tracked_valid_ff <= 1'b1;
      end
   end

   assign centre_x_in = OUT_BITS'(tracked_x_in);
   assign centre_y_in = OUT_BITS'(tracked_y_in);

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= s1_valid_ff && s1_item_ff.object_present;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_item_ff.object_present) begin
         centre_x_ff    <= centre_x_in;
         centre_y_ff    <= centre_y_in;
         view_left_ff   <= centre_x_in - OUT_BITS'(VIEW_HALF_W);
         view_top_ff    <= centre_y_in - OUT_BITS'(VIEW_HALF_H);
         view_right_ff  <= centre_x_in + OUT_BITS'(VIEW_HALF_W);
         view_bottom_ff <= centre_y_in + OUT_BITS'(VIEW_HALF_H);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.centre_x    = centre_x_ff;
   assign rsp_chan.centre_y    = centre_y_ff;
   assign rsp_chan.view_left   = view_left_ff;
   assign rsp_chan.view_top    = view_top_ff;
   assign rsp_chan.view_right  = view_right_ff;
   assign rsp_chan.view_bottom = view_bottom_ff;

endmodule

FILE: hdl/wslt_checker.sv
// wslt_checker: port-level assertions for the tracker top level
// depends on wslt_pkg; bound to wrapped_slew_limited_tracker_unit
`timescale 1ns / 1ps

module wslt_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 req_object_present,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [wslt_pkg::OUT_BITS-1:0] centre_x,
   input logic signed [wslt_pkg::OUT_BITS-1:0] centre_y,
   input logic signed [wslt_pkg::OUT_BITS-1:0] view_left,
   input logic signed [wslt_pkg::OUT_BITS-1:0] view_top,
   input logic signed [wslt_pkg::OUT_BITS-1:0] view_right,
   input logic signed [wslt_pkg::OUT_BITS-1:0] view_bottom
);
   import wslt_pkg::*;

   logic [OUT_BITS-1:0] width_span;
   logic [OUT_BITS-1:0] height_span;

   assign width_span  = view_right - view_left;
   assign height_span = view_bottom - view_top;

   // result held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(centre_x) && $stable(centre_y))
      else $error("rsp transaction dropped or changed while stalled");

   // viewport spans 128 by 96 around the centre
   a_view_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> width_span == OUT_BITS'(2 * VIEW_HALF_W)
                 && height_span == OUT_BITS'(2 * VIEW_HALF_H))
      else $error("viewport size wrong");

   a_view_centre: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> view_left == centre_x - OUT_BITS'(VIEW_HALF_W)
                 && view_top == centre_y - OUT_BITS'(VIEW_HALF_H))
      else $error("viewport not around centre");

   // a present transaction accepted while no result is held reaches rsp valid through the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_object_present && !rsp_valid && rsp_ready
      |=> ##1 rsp_valid)
      else $error("rsp transaction missing after present request");

endmodule

bind wrapped_slew_limited_tracker_unit wslt_checker u_wslt_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .req_object_present (req_chan.object_present),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .centre_x           (rsp_chan.centre_x),
   .centre_y           (rsp_chan.centre_y),
   .view_left          (rsp_chan.view_left),
   .view_top           (rsp_chan.view_top),
   .view_right         (rsp_chan.view_right),
   .view_bottom        (rsp_chan.view_bottom)
);

FILE: verif/testbench.sv
// testbench: self-checking bench for wrapped_slew_limited_tracker_unit
// keeps its own model of the tracker state, drives directed and random ticks,
// checks every result in order; depends on wslt_pkg, wslt_req_if, wslt_rsp_if
`timescale 1ns / 1ps

module testbench;
   import wslt_pkg::*;

   localparam int TRACK_BITS     = COORD_BITS_DEFAULT;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int NUM_PHASES     = 6;
   localparam int RANDOM_TICKS   = 170;
   localparam int DRAIN_EVERY    = 250;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] centre_x;
      logic signed [OUT_BITS-1:0] centre_y;
      logic signed [OUT_BITS-1:0] view_left;
      logic signed [OUT_BITS-1:0] view_top;
      logic signed [OUT_BITS-1:0] view_right;
      logic signed [OUT_BITS-1:0] view_bottom;
   } view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_write_data;

   wslt_req_if req_chan ();
   wslt_rsp_if rsp_chan ();

   wrapped_slew_limited_tracker_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // world size as the block currently holds it
   int world_w = WORLD_WIDTH_RESET;
   int world_h = WORLD_HEIGHT_RESET;

   // tracked centre as the block should hold it
   logic signed [TRACK_BITS-1:0] trk_x = '0;
   logic signed [TRACK_BITS-1:0] trk_y = '0;
   logic trk_valid = 1'b0;

   item_type pending_ticks[$];
   view_type expected_views[$];
   item_type req_item;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;
   int ticks_sent     = 0;
   int views_checked  = 0;
   int quiet_cycles   = 0;
   int walk_x         = 4000;
   int walk_y         = 0;
   bit draining       = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic view_type advance_tracker(item_type it);
      int tx, ty, cx, cy, delta, half, mag;
      view_type v;
      if (!it.has_motion_goal || it.asleep || int'(it.goal_y) > world_h) begin
         tx = int'(it.source_x) + int'(it.object_width) / 2;
         if (tx >= world_w)
            tx -= world_w;
         else if (tx < 0)
            tx += world_w;
         ty = int'(it.source_y) + int'(it.object_height) / 2;
      end else begin
         tx = it.goal_x;
         ty = it.goal_y;
      end
      cx = trk_x;
      cy = trk_y;
      half = world_w / 2;
      delta = tx - cx;
      if (delta < -half)
         delta += world_w;
      else if (delta > half)
         delta -= world_w;
      mag = (delta < 0) ? -delta : delta;
      if (!trk_valid || mag > SNAP_DIST) begin
         cx = tx;
         cy = ty;
      end else begin
         // direction from folded distance, clamp against unfolded centre
         if (delta < 0) begin
            cx -= STEP_SIZE;
            if (cx < tx) cx = tx;
         end else if (delta > 0) begin
            cx += STEP_SIZE;
            if (cx > tx) cx = tx;
         end
         if (cy < ty) begin
            cy += STEP_SIZE;
            if (cy > ty) cy = ty;
         end else if (cy > ty) begin
            cy -= STEP_SIZE;
            if (cy < ty) cy = ty;
         end
      end
      trk_x = cx[TRACK_BITS-1:0];
      trk_y = cy[TRACK_BITS-1:0];
      trk_valid = 1'b1;
      cx = trk_x;
      cy = trk_y;
      v.centre_x    = OUT_BITS'(cx);
      v.centre_y    = OUT_BITS'(cy);
      v.view_left   = OUT_BITS'(cx - VIEW_HALF_W);
      v.view_top    = OUT_BITS'(cy - VIEW_HALF_H);
      v.view_right  = OUT_BITS'(cx + VIEW_HALF_W);
      v.view_bottom = OUT_BITS'(cy + VIEW_HALF_H);
      return v;
   endfunction

   function automatic item_type make_tick(bit present, bit goal, bit sleeping, int gx, int gy,
                                          int sx, int sy, int w, int h);
      item_type it;
      it.object_present  = present;
      it.has_motion_goal = goal;
      it.asleep          = sleeping;
      it.goal_x          = POS_BITS'(gx);
      it.goal_y          = POS_BITS'(gy);
      it.source_x        = POS_BITS'(sx);
      it.source_y        = POS_BITS'(sy);
      it.object_width    = SIZE_BITS'(w);
      it.object_height   = SIZE_BITS'(h);
      return it;
   endfunction

   task automatic check_field(string name, logic signed [OUT_BITS-1:0] exp_v,
                              logic signed [OUT_BITS-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         error_count++;
      end
   endtask

   // mostly ticks that follow a slowly moving point, so the centre steps
   // rather than snaps; the rest are absent ticks and fully random ones
   task automatic load_random(int count);
      logic [95:0] raw;
      item_type it;
      int pick, sx, hi_y, choice;
      repeat (count) begin
         pick = $urandom_range(99);
         raw = {$urandom, $urandom, $urandom};
         it = raw[$bits(item_type)-1:0];
         if (pick < 8) begin
            it.object_present = 1'b0;
         end else if (pick < 78) begin
            it.object_present = 1'b1;
            walk_x += int'($urandom_range(60)) - 30;
            walk_y += int'($urandom_range(60)) - 30;
            if (pick >= 72) begin
               walk_x += int'($urandom_range(2000)) - 1000;
               walk_y += int'($urandom_range(2000)) - 1000;
            end
            if (world_w > 0)
               walk_x = ((walk_x % world_w) + world_w) % world_w;
            else if (walk_x > 15000)
               walk_x = 15000;
            else if (walk_x < -15000)
               walk_x = -15000;
            hi_y = (world_h < 15000) ? world_h : 15000;
            if (walk_y > hi_y) walk_y = hi_y;
            if (walk_y < -15000) walk_y = -15000;
            if (pick < 45) begin
               it.has_motion_goal = 1'b1;
               it.asleep          = 1'b0;
               it.goal_x          = POS_BITS'(walk_x);
               it.goal_y          = POS_BITS'(walk_y);
            end else begin
               choice = $urandom_range(2);
               if (choice == 0) begin
                  it.has_motion_goal = 1'b0;
               end else if (choice == 1 || world_h >= 16383) begin
                  it.asleep = 1'b1;
               end else begin
                  it.has_motion_goal = 1'b1;
                  it.asleep          = 1'b0;
                  it.goal_y          = POS_BITS'(int'($urandom_range(16383, world_h + 1)));
               end
               sx = walk_x - int'(it.object_width) / 2;
               // push the object a world width away so its centre wraps back
               if ($urandom_range(3) == 0) begin
                  if (pick[0]) sx += world_w;
                  else sx -= world_w;
                  if (sx > 16383 || sx < -16384)
                     sx = walk_x - int'(it.object_width) / 2;
               end
               it.source_x = POS_BITS'(sx);
               it.source_y = POS_BITS'(walk_y - int'(it.object_height) / 2);
            end
         end
         pending_ticks.push_back(it);
      end
   endtask

   task automatic wait_idle();
      while (pending_ticks.size() != 0 || req_chan.valid || expected_views.size() != 0)
         @(posedge clock);
      // absent ticks leave nothing to wait for, so let the pipeline empty
      repeat (8) @(posedge clock);
   endtask

   task automatic write_world(int ww, int wh);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_WORLD_WIDTH;
      csr_write_data   <= CSR_DATA_BITS'(ww);
      @(posedge clock);
      csr_index        <= CSR_WORLD_HEIGHT;
      csr_write_data   <= CSR_DATA_BITS'(wh);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      world_w = ww;
      world_h = wh;
      @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin : drive_ticks
      item_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            ticks_sent++;
            if (req_item.object_present)
               expected_views.push_back(advance_tracker(req_item));
            if (ticks_sent % DRAIN_EVERY == 0)
               draining = 1'b1;
         end
         if (draining && expected_views.size() == 0)
            draining = 1'b0;
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_ticks.size() != 0 && !draining &&
                $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_ticks.pop_front();
               req_item                 <= nxt;
               req_chan.object_present  <= nxt.object_present;
               req_chan.has_motion_goal <= nxt.has_motion_goal;
               req_chan.asleep          <= nxt.asleep;
               req_chan.goal_x          <= nxt.goal_x;
               req_chan.goal_y          <= nxt.goal_y;
               req_chan.source_x        <= nxt.source_x;
               req_chan.source_y        <= nxt.source_y;
               req_chan.object_width    <= nxt.object_width;
               req_chan.object_height   <= nxt.object_height;
               req_chan.valid           <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : check_views
      view_type exp_v;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            views_checked++;
            if (expected_views.size() == 0) begin
               $error("unexpected result transaction: centre_x %0d centre_y %0d",
                      rsp_chan.centre_x, rsp_chan.centre_y);
               error_count++;
            end else begin
               exp_v = expected_views.pop_front();
               check_field("centre_x", exp_v.centre_x, rsp_chan.centre_x);
               check_field("centre_y", exp_v.centre_y, rsp_chan.centre_y);
               check_field("view_left", exp_v.view_left, rsp_chan.view_left);
               check_field("view_top", exp_v.view_top, rsp_chan.view_top);
               check_field("view_right", exp_v.view_right, rsp_chan.view_right);
               check_field("view_bottom", exp_v.view_bottom, rsp_chan.view_bottom);
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (pending_ticks.size() == 0 && expected_views.size() == 0 && !req_chan.valid)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles without a transaction", quiet_cycles);
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase_width[NUM_PHASES]  = '{8192, 16383, 1, 0, 1280, 5000};
      int phase_height[NUM_PHASES] = '{2048, 16383, 0, 1, 16383, 100};
      int phase_send[NUM_PHASES]   = '{0, 61, 0, 22, 0, 22};
      int phase_recv[NUM_PHASES]   = '{0, 0, 61, 22, 0, 22};
      int ww;
      req_chan.valid           = 1'b0;
      req_chan.object_present  = 1'b0;
      req_chan.has_motion_goal = 1'b0;
      req_chan.asleep          = 1'b0;
      req_chan.goal_x          = '0;
      req_chan.goal_y          = '0;
      req_chan.source_x        = '0;
      req_chan.source_y        = '0;
      req_chan.object_width    = '0;
      req_chan.object_height   = '0;
      rsp_chan.ready           = 1'b0;
      csr_write_enable         = 1'b0;
      csr_index                = CSR_WORLD_WIDTH;
      csr_write_data           = '0;
      req_item                 = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed ticks under the reset world size
      pending_ticks.push_back(make_tick(0, 1, 1, -1, -1, -1, -1, 1023, 1023));
      pending_ticks.push_back(make_tick(1, 0, 0, 0, 0, -16384, -16384, 1023, 1023));
      pending_ticks.push_back(make_tick(1, 1, 0, 100, 200, 0, 0, 0, 0));
      pending_ticks.push_back(make_tick(1, 1, 1, 5000, 5000, 0, 0, 0, 0));
      pending_ticks.push_back(make_tick(1, 1, 0, 300, 2049, 50, -15841, 20, 0));
      pending_ticks.push_back(make_tick(1, 1, 0, 70, 2048, 0, 0, 0, 0));
      pending_ticks.push_back(make_tick(1, 1, 0, 5000, 0, 0, 0, 0, 0));
      pending_ticks.push_back(make_tick(1, 1, 0, 5640, 0, 0, 0, 0, 0));
      pending_ticks.push_back(make_tick(1, 1, 0, 5657, 10, 0, 0, 0, 0));
      pending_ticks.push_back(make_tick(1, 1, 0, 5017, 10, 0, 0, 0, 0));
      pending_ticks.push_back(make_tick(1, 1, 0, 5000, 10, 0, 0, 0, 0));
      pending_ticks.push_back(make_tick(1, 1, 0, 5008, 20, 0, 0, 0, 0));
      pending_ticks.push_back(make_tick(1, 1, 0, 5008, 20, 0, 0, 0, 0));
      pending_ticks.push_back(make_tick(1, 1, 0, 5008, 4, 0, 0, 0, 0));
      pending_ticks.push_back(make_tick(1, 1, 0, 5008, -100, 0, 0, 0, 0));
      pending_ticks.push_back(make_tick(1, 1, 0, 10, 0, 0, 0, 0, 0));
      pending_ticks.push_back(make_tick(1, 1, 0, 8190, 0, 0, 0, 0, 0));
      pending_ticks.push_back(make_tick(1, 1, 0, 5, 0, 0, 0, 0, 0));
      pending_ticks.push_back(make_tick(1, 1, 0, 16383, 16383, 16383, 16383, 1023, 1023));
      pending_ticks.push_back(make_tick(1, 1, 0, -16384, -16384, 0, 0, 0, 0));
      pending_ticks.push_back(make_tick(1, 0, 0, 16383, 0, -1, -1, 0, 0));
      pending_ticks.push_back(make_tick(1, 0, 1, 0, 0, 100, 100, 1, 3));
      pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, 0, 0, 0, 0));

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            wait_idle();
            ww = phase_width[p];
            if (p == 4) ww = $urandom_range(16383, 1);
            write_world(ww, phase_height[p]);
         end
         send_idle_pct  = phase_send[p];
         recv_stall_pct = phase_recv[p];
         load_random(RANDOM_TICKS);
      end
      wait_idle();

      $display("sent %0d tick transactions and checked %0d results", ticks_sent, views_checked);
      $display("over %0d world size settings incl. zero and full range", NUM_PHASES);
      if (error_count == 0 && expected_views.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/wslt_pkg.sv
hdl/wslt_req_if.sv
hdl/wslt_rsp_if.sv
hdl/wslt_target.sv
hdl/wslt_step.sv
hdl/wrapped_slew_limited_tracker_unit.sv
hdl/wslt_checker.sv
verif/testbench.sv
